// File: sv/bve_pkg.sv
// Shared types and constants for the bytecode varint encoder.
// No dependencies; every other file refers to this package by scoped names.
package bve_pkg;

    // Format codes carried on the cmd field
    localparam logic [2:0] CMD_OPCODE = 3'd0;
    localparam logic [2:0] CMD_INDEX  = 3'd1;
    localparam logic [2:0] CMD_UVAR   = 3'd2;
    localparam logic [2:0] CMD_SVAR   = 3'd3;
    localparam logic [2:0] CMD_DOUBLE = 3'd4;

    // Largest count of bytes after the lead byte
    localparam logic [3:0] MAX_TAIL = 4'd8;

    // Opcode lead-byte range limits
    localparam logic [31:0] OP_LIM4 = 32'd50331648;
    localparam logic [31:0] OP_LIM3 = 32'd786432;
    localparam logic [31:0] OP_LIM2 = 32'd12288;
    localparam logic [31:0] OP_LIM1 = 32'd192;

    // Prefix varint range limits
    localparam logic [63:0] VLI_LIM0 = 64'h0000_0000_0000_0080;
    localparam logic [63:0] VLI_LIM1 = 64'h0000_0000_0000_4000;
    localparam logic [63:0] VLI_LIM2 = 64'h0000_0000_0020_0000;
    localparam logic [63:0] VLI_LIM3 = 64'h0000_0000_1000_0000;
    localparam logic [63:0] VLI_LIM4 = 64'h0000_0008_0000_0000;
    localparam logic [63:0] VLI_LIM5 = 64'h0000_0400_0000_0000;
    localparam logic [63:0] VLI_LIM6 = 64'h0002_0000_0000_0000;
    localparam logic [63:0] VLI_LIM7 = 64'h0100_0000_0000_0000;

    // Exponent bias plus mantissa width
    localparam logic signed [11:0] EXP_OFS = 12'sd1075;

    typedef enum logic [1:0] {
        FMT_OP,
        FMT_IDX,
        FMT_VLI
    } t_fmt;

    typedef enum logic [2:0] {
        ALU_MANT,
        ALU_SHR1,
        ALU_SHR4,
        ALU_NEG,
        ALU_ZZ,
        ALU_SEXT
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DPREP,
        ST_STRIP,
        ST_DNEG,
        ST_ZZ,
        ST_CODE,
        ST_LEAD,
        ST_TAIL,
        ST_EXP
    } t_state;

    // Lead byte and count of following bytes for one run
    typedef struct packed {
        logic [7:0] lead;
        logic [3:0] ntail;
    } t_run;

endpackage

// File: sv/bytecode_varint_encoder_top.sv
// Bytecode varint encoder. Opcode, index and unsigned items pass the code
// and lead states, then one byte per cycle while the output is not stalled;
// signed varints first pass the zigzag state. Nonzero doubles pass prep, the
// trailing-zero strip loop (a nibble or a bit per step) and a negate state
// if negative, then send mantissa and exponent runs; an all-zero pattern skips
// the strip loop and sends its 2 bytes. The input stalls until the item is done.
// Synchronous active-low reset empties the output slot and idles the sequencer.
module bytecode_varint_encoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_cmd,
    input  logic signed [63:0] i_value,
    // result item channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_last_byte
);

    // Sequencer state and datapath registers
    bve_pkg::t_state    r_state, n_state;
    logic [2:0]         r_cmd, n_cmd;
    logic [63:0]        r_w, n_w;          // working word, loaded from the input, then fed by the shared unit
    logic signed [11:0] r_e, n_e;          // double exponent
    logic               r_neg, n_neg;      // double sign
    logic               r_seg2, n_seg2;    // exponent run still pending
    logic [7:0]         r_lead, n_lead;
    logic [3:0]         r_k, n_k;          // tail bytes still to send

    // Output slot
    logic               r_ovalid;
    logic [7:0]         r_obyte;
    logic               r_olast;

    logic               w_accept;
    logic               w_slot;
    logic               w_emit;
    logic               w_last;
    logic [7:0]         w_byte;
    logic [2:0]         w_bsel;
    logic               w_wzero;
    bve_pkg::t_alu_op   w_op;
    logic [63:0]        w_alu_y;
    bve_pkg::t_fmt      w_fmt;
    bve_pkg::t_run      w_run;

    assign o_stall     = (r_state != bve_pkg::ST_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign w_slot      = !r_ovalid || !i_stall;
    assign o_valid     = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_last_byte = r_olast;
    assign w_wzero     = (r_w == 64'd0);

    // Tail bytes go out high first: byte k-1 of the word
    assign w_bsel = r_k[2:0] - 3'd1;

    bve_alu u_alu (
        .i_op (w_op),
        .i_a  (r_w),
        .i_e  (r_e),
        .o_y  (w_alu_y)
    );

    // Pick the lead-byte rule for the format
    always_comb begin
        unique case (r_cmd)
            bve_pkg::CMD_OPCODE: w_fmt = bve_pkg::FMT_OP;
            bve_pkg::CMD_INDEX:  w_fmt = bve_pkg::FMT_IDX;
            default:             w_fmt = bve_pkg::FMT_VLI;
        endcase
    end

    bve_fmt u_fmt (
        .i_fmt (w_fmt),
        .i_u   (r_w),
        .o_run (w_run)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bve_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_cmd) inside
                        bve_pkg::CMD_OPCODE, bve_pkg::CMD_INDEX,
                        bve_pkg::CMD_UVAR:   n_state = bve_pkg::ST_CODE;
                        bve_pkg::CMD_SVAR:   n_state = bve_pkg::ST_ZZ;
                        bve_pkg::CMD_DOUBLE: n_state = bve_pkg::ST_DPREP;
                        default:             n_state = bve_pkg::ST_IDLE;  // drop unused codes
                    endcase
                end
            end
            bve_pkg::ST_DPREP: n_state = w_wzero ? bve_pkg::ST_ZZ : bve_pkg::ST_STRIP;
            bve_pkg::ST_STRIP: begin
                if (r_w[0]) begin
                    n_state = r_neg ? bve_pkg::ST_DNEG : bve_pkg::ST_ZZ;
                end
            end
            bve_pkg::ST_DNEG: n_state = bve_pkg::ST_ZZ;
            bve_pkg::ST_ZZ:   n_state = bve_pkg::ST_CODE;
            bve_pkg::ST_CODE: n_state = bve_pkg::ST_LEAD;
            bve_pkg::ST_LEAD: begin
                if (w_slot) begin
                    if (r_k != 4'd0) begin
                        n_state = bve_pkg::ST_TAIL;
                    end else begin
                        n_state = r_seg2 ? bve_pkg::ST_EXP : bve_pkg::ST_IDLE;
                    end
                end
            end
            bve_pkg::ST_TAIL: begin
                if (w_slot && r_k == 4'd1) begin
                    n_state = r_seg2 ? bve_pkg::ST_EXP : bve_pkg::ST_IDLE;
                end
            end
            bve_pkg::ST_EXP: n_state = bve_pkg::ST_ZZ;
            default:         n_state = bve_pkg::ST_IDLE;
        endcase
    end

    // Datapath control and emission
    always_comb begin
        n_cmd  = r_cmd;
        n_w    = r_w;
        n_e    = r_e;
        n_neg  = r_neg;
        n_seg2 = r_seg2;
        n_lead = r_lead;
        n_k    = r_k;
        w_op   = bve_pkg::ALU_ZZ;
        w_emit = 1'b0;
        w_last = 1'b0;
        w_byte = r_lead;
        unique case (r_state)
            bve_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_cmd  = i_cmd;
                    n_w    = i_value;
                    n_seg2 = (i_cmd == bve_pkg::CMD_DOUBLE);
                end
            end
            bve_pkg::ST_DPREP: begin
                // An all-zero pattern sends zero mantissa and zero exponent
                w_op  = bve_pkg::ALU_MANT;
                n_neg = r_w[63];
                if (w_wzero) begin
                    n_e = 12'sd0;
                end else begin
                    n_w = w_alu_y;
                    n_e = $signed({1'b0, r_w[62:52]}) - bve_pkg::EXP_OFS;
                end
            end
            bve_pkg::ST_STRIP: begin
                // Strip a nibble when possible, else a single bit
                if (r_w[3:0] == 4'd0) begin
                    w_op = bve_pkg::ALU_SHR4;
                    n_w  = w_alu_y;
                    n_e  = r_e + 12'sd4;
                end else if (!r_w[0]) begin
                    w_op = bve_pkg::ALU_SHR1;
                    n_w  = w_alu_y;
                    n_e  = r_e + 12'sd1;
                end
            end
            bve_pkg::ST_DNEG: begin
                w_op = bve_pkg::ALU_NEG;
                n_w  = w_alu_y;
            end
            bve_pkg::ST_ZZ: begin
                w_op = bve_pkg::ALU_ZZ;
                n_w  = w_alu_y;
            end
            bve_pkg::ST_CODE: begin
                n_lead = w_run.lead;
                n_k    = w_run.ntail;
            end
            bve_pkg::ST_LEAD: begin
                w_emit = w_slot;
                w_byte = r_lead;
                w_last = (r_k == 4'd0) && !r_seg2;
                if (w_slot && r_k == 4'd0) begin
                    n_seg2 = 1'b0;
                end
            end
            bve_pkg::ST_TAIL: begin
                w_emit = w_slot;
                w_byte = r_w[{w_bsel, 3'b000} +: 8];
                w_last = (r_k == 4'd1) && !r_seg2;
                if (w_slot) begin
                    n_k = r_k - 4'd1;
                    if (r_k == 4'd1) begin
                        n_seg2 = 1'b0;
                    end
                end
            end
            bve_pkg::ST_EXP: begin
                w_op = bve_pkg::ALU_SEXT;
                n_w  = w_alu_y;
            end
            default: begin
                n_seg2 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bve_pkg::ST_IDLE;
            r_seg2   <= 1'b0;
            r_k      <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seg2  <= n_seg2;
            r_k     <= n_k;
            // Fill the slot on emit, drain it when taken
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_w    <= n_w;
        r_e    <= n_e;
        r_neg  <= n_neg;
        r_lead <= n_lead;
        if (w_emit) begin
            r_obyte <= w_byte;
            r_olast <= w_last;
        end
    end

    // Strip loop never sees a zero word, so it always ends
    a_strip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bve_pkg::ST_STRIP |-> !w_wzero)
        else $error("strip step on zero word");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= bve_pkg::MAX_TAIL)
        else $error("tail count out of range");

    a_seg2_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seg2 && r_state != bve_pkg::ST_IDLE) |-> r_cmd == bve_pkg::CMD_DOUBLE)
        else $error("exponent run pending on non-double item");

    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bve_pkg::ST_TAIL && r_ovalid && i_stall)
        |=> (r_state == bve_pkg::ST_TAIL && $stable(r_k)))
        else $error("tail advanced while output slot was stalled");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> r_state == bve_pkg::ST_IDLE)
        else $error("sequencer busy after last byte");

endmodule

// File: sv/bve_alu.sv
// Shared 64-bit word unit of the encoder: mantissa build, shifts, negate,
// zigzag map and exponent sign extension. Uses bve_pkg.
module bve_alu (
    input  bve_pkg::t_alu_op     i_op,
    input  logic [63:0]          i_a,
    input  logic signed [11:0]   i_e,
    output logic [63:0]          o_y
);

    always_comb begin
        unique case (i_op)
            bve_pkg::ALU_MANT: o_y = {11'd0, 1'b1, i_a[51:0]};
            bve_pkg::ALU_SHR1: o_y = {1'b0, i_a[63:1]};
            bve_pkg::ALU_SHR4: o_y = {4'd0, i_a[63:4]};
            bve_pkg::ALU_NEG:  o_y = 64'd0 - i_a;
            // -2v-1 equals the inverse of 2v
            bve_pkg::ALU_ZZ:   o_y = i_a[63] ? ~{i_a[62:0], 1'b0} : {i_a[62:0], 1'b0};
            bve_pkg::ALU_SEXT: o_y = {{52{i_e[11]}}, i_e};
            default:           o_y = i_a;
        endcase
    end

endmodule

// File: sv/bve_fmt.sv
// Lead byte and tail length decoder for opcode, index and prefix varint runs.
// Uses bve_pkg for the range limits and the run struct.
module bve_fmt (
    input  bve_pkg::t_fmt  i_fmt,
    input  logic [63:0]    i_u,
    output bve_pkg::t_run  o_run
);

    logic [31:0] w_w;

    assign w_w = i_u[31:0];

    always_comb begin
        o_run = '{lead: w_w[7:0], ntail: 4'd0};
        unique case (i_fmt)
            bve_pkg::FMT_OP: begin
                if (w_w[31]) begin
                    o_run = '{lead: w_w[7:0], ntail: 4'd0};
                end else if (w_w >= bve_pkg::OP_LIM4) begin
                    o_run = '{lead: 8'hFF, ntail: 4'd4};
                end else if (w_w >= bve_pkg::OP_LIM3) begin
                    o_run = '{lead: w_w[31:24] + 8'd252, ntail: 4'd3};
                end else if (w_w >= bve_pkg::OP_LIM2) begin
                    o_run = '{lead: w_w[23:16] + 8'd240, ntail: 4'd2};
                end else if (w_w >= bve_pkg::OP_LIM1) begin
                    o_run = '{lead: w_w[15:8] + 8'd192, ntail: 4'd1};
                end
            end
            bve_pkg::FMT_IDX: begin
                if (w_w[31] || w_w < bve_pkg::VLI_LIM0[31:0]) begin
                    o_run = '{lead: w_w[7:0], ntail: 4'd0};
                end else if (w_w < bve_pkg::VLI_LIM1[31:0]) begin
                    o_run = '{lead: w_w[15:8] | 8'h80, ntail: 4'd1};
                end else if (w_w < bve_pkg::VLI_LIM2[31:0]) begin
                    o_run = '{lead: w_w[23:16] | 8'hC0, ntail: 4'd2};
                end else if (w_w < bve_pkg::VLI_LIM3[31:0]) begin
                    o_run = '{lead: w_w[31:24] | 8'hE0, ntail: 4'd3};
                end else begin
                    o_run = '{lead: 8'hF0, ntail: 4'd4};
                end
            end
            default: begin
                if (i_u[63]) begin
                    o_run = '{lead: 8'h00, ntail: 4'd0};
                end else if (i_u < bve_pkg::VLI_LIM0) begin
                    o_run = '{lead: i_u[7:0], ntail: 4'd0};
                end else if (i_u < bve_pkg::VLI_LIM1) begin
                    o_run = '{lead: i_u[15:8] | 8'h80, ntail: 4'd1};
                end else if (i_u < bve_pkg::VLI_LIM2) begin
                    o_run = '{lead: i_u[23:16] | 8'hC0, ntail: 4'd2};
                end else if (i_u < bve_pkg::VLI_LIM3) begin
                    o_run = '{lead: i_u[31:24] | 8'hE0, ntail: 4'd3};
                end else if (i_u < bve_pkg::VLI_LIM4) begin
                    o_run = '{lead: i_u[39:32] | 8'hF0, ntail: 4'd4};
                end else if (i_u < bve_pkg::VLI_LIM5) begin
                    o_run = '{lead: i_u[47:40] | 8'hF8, ntail: 4'd5};
                end else if (i_u < bve_pkg::VLI_LIM6) begin
                    o_run = '{lead: i_u[55:48] | 8'hFC, ntail: 4'd6};
                end else if (i_u < bve_pkg::VLI_LIM7) begin
                    o_run = '{lead: 8'hFE, ntail: 4'd7};
                end else begin
                    o_run = '{lead: 8'hFF, ntail: 4'd8};
                end
            end
        endcase
    end

endmodule

// File: tb/tb.sv
// Self-checking testbench for bytecode_varint_encoder_top: directed edge values,
// random items and a long output hold-off, each byte checked against a local encoder.
// Depends on bve_pkg for the format codes and range limits.
module tb;

    // Codes with no encoding behind them
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 500;
    localparam int MAX_RUN      = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_enc_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_cmd = '0;
    logic [63:0] i_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    // Bytes still owed by the block, oldest first
    t_enc_byte  want_q[$];
    // Scratch run built by the encoder functions for one item
    logic [7:0] run_bytes[$];
    t_enc_byte  head_byte;

    int n_err      = 0;
    int n_sent     = 0;
    int n_silent   = 0;
    int n_bytes    = 0;
    int cycle_cnt  = 0;
    int stall_left = 0;
    int hold_cycles = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    bytecode_varint_encoder_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Local encoder: append the bytes of one item to run_bytes
    // ---------------------------------------------------------------

    // Append a lead byte, then 'tail' bytes of u, most significant first
    function automatic void emit_tail(input logic [63:0] lead, input logic [63:0] u,
                                      input int tail);
        run_bytes.push_back(lead[7:0]);
        for (int k = tail - 1; k >= 0; k--)
            run_bytes.push_back(u[8*k +: 8]);
    endfunction

    function automatic void enc_opcode(input logic [63:0] v);
        logic [63:0] w;
        w = {32'd0, v[31:0]};
        // Negative opcodes fall through to a single low byte
        if (w[31])
            run_bytes.push_back(w[7:0]);
        else if (w >= bve_pkg::OP_LIM4)
            emit_tail(64'hFF, w, 4);
        else if (w >= bve_pkg::OP_LIM3)
            emit_tail((w >> 24) + 64'd252, w, 3);
        else if (w >= bve_pkg::OP_LIM2)
            emit_tail((w >> 16) + 64'd240, w, 2);
        else if (w >= bve_pkg::OP_LIM1)
            emit_tail((w >> 8) + 64'd192, w, 1);
        else
            run_bytes.push_back(w[7:0]);
    endfunction

    function automatic void enc_index(input logic [63:0] v);
        logic [63:0] w;
        w = {32'd0, v[31:0]};
        if (w[31] || w < bve_pkg::VLI_LIM0)
            run_bytes.push_back(w[7:0]);
        else if (w < bve_pkg::VLI_LIM1)
            emit_tail((w >> 8) | 64'h80, w, 1);
        else if (w < bve_pkg::VLI_LIM2)
            emit_tail((w >> 16) | 64'hC0, w, 2);
        else if (w < bve_pkg::VLI_LIM3)
            emit_tail((w >> 24) | 64'hE0, w, 3);
        else
            emit_tail(64'hF0, w, 4);
    endfunction

    function automatic void enc_uvar(input logic [63:0] u);
        // A set top bit collapses to one zero byte
        if (u[63])
            run_bytes.push_back(8'h00);
        else if (u < bve_pkg::VLI_LIM0)
            run_bytes.push_back(u[7:0]);
        else if (u < bve_pkg::VLI_LIM1)
            emit_tail((u >> 8) | 64'h80, u, 1);
        else if (u < bve_pkg::VLI_LIM2)
            emit_tail((u >> 16) | 64'hC0, u, 2);
        else if (u < bve_pkg::VLI_LIM3)
            emit_tail((u >> 24) | 64'hE0, u, 3);
        else if (u < bve_pkg::VLI_LIM4)
            emit_tail((u >> 32) | 64'hF0, u, 4);
        else if (u < bve_pkg::VLI_LIM5)
            emit_tail((u >> 40) | 64'hF8, u, 5);
        else if (u < bve_pkg::VLI_LIM6)
            emit_tail((u >> 48) | 64'hFC, u, 6);
        else if (u < bve_pkg::VLI_LIM7)
            emit_tail((u >> 56) | 64'hFE, u, 7);
        else
            emit_tail(64'hFF, u, 8);
    endfunction

    function automatic void enc_svar(input logic [63:0] v);
        logic [63:0] z;
        if (v[63])
            z = ((-v) << 1) - 64'd1;
        else
            z = v << 1;
        enc_uvar(z);
    endfunction

    function automatic void enc_double(input logic [63:0] bits);
        logic [63:0] mant;
        logic [63:0] expo;
        if (bits == 64'd0) begin
            enc_svar(64'd0);
            enc_svar(64'd0);
        end else begin
            // Hidden bit is set for every exponent, specials included
            mant = {11'd0, 1'b1, bits[51:0]};
            expo = {53'd0, bits[62:52]} - 64'd1075;
            if (bits[63])
                mant = -mant;
            while (!mant[0]) begin
                mant = {mant[63], mant[63:1]};
                expo = expo + 64'd1;
            end
            enc_svar(mant);
            enc_svar(expo);
        end
    endfunction

    // Queue the bytes an accepted item must produce; return how many
    function automatic int predict_encoding(input logic [2:0] cmd, input logic [63:0] value);
        int n;
        run_bytes.delete();
        case (cmd)
            bve_pkg::CMD_OPCODE: enc_opcode(value);
            bve_pkg::CMD_INDEX:  enc_index(value);
            bve_pkg::CMD_UVAR:   enc_uvar(value);
            bve_pkg::CMD_SVAR:   enc_svar(value);
            bve_pkg::CMD_DOUBLE: enc_double(value);
            default:    ;
        endcase
        while (run_bytes.size() > MAX_RUN)
            void'(run_bytes.pop_back());
        n = run_bytes.size();
        for (int k = 0; k < n; k++)
            want_q.push_back('{data: run_bytes[k], last: (k == n - 1)});
        return n;
    endfunction

    // ---------------------------------------------------------------
    // Random value shaping
    // ---------------------------------------------------------------

    // Mix of full words, values near powers of two and their negatives, small
    // values and values near the opcode range limits
    function automatic logic [63:0] rand_word();
        logic [63:0] r;
        logic [63:0] ofs;
        int k;
        r   = {$urandom, $urandom};
        k   = $urandom_range(0, 63);
        ofs = 64'($urandom_range(0, 3));
        case ($urandom_range(0, 4))
            0: ;
            1: r = (64'd1 << k) + ofs - 64'd2;
            2: r = 64'($urandom_range(0, 400));
            3: r = -((64'd1 << k) + ofs - 64'd2);
            default: begin
                case ($urandom_range(0, 3))
                    0: r = {32'd0, bve_pkg::OP_LIM1};
                    1: r = {32'd0, bve_pkg::OP_LIM2};
                    2: r = {32'd0, bve_pkg::OP_LIM3};
                    default: r = {32'd0, bve_pkg::OP_LIM4};
                endcase
                r = r + ofs - 64'd2;
            end
        endcase
        return r;
    endfunction

    // Doubles with random exponent ranges and stretches of trailing zeros
    function automatic logic [63:0] rand_double();
        logic [63:0] r;
        logic [63:0] mask;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: ;
            1: begin
                mask = (64'd1 << $urandom_range(0, 52)) - 64'd1;
                r[51:0] = r[51:0] & ~mask[51:0];
            end
            2: r[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
            3: r[62:52] = 11'd1023 + 11'($urandom_range(0, 20)) - 11'd10;
            default: r = {r[63], 63'd0} | (64'd1 << $urandom_range(0, 62));
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input side: offer one item after a random gap, hold it until taken
    // ---------------------------------------------------------------
    task automatic send_item(input logic [2:0] cmd, input logic [63:0] value);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        do
            @(posedge i_clk);
        while (o_stall);
        n_sent++;
        if (predict_encoding(cmd, value) == 0)
            n_silent++;
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Output side: stall driver, counted in cycles at the falling edge.
    // A long hold-off takes priority over the per-byte random stall.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles--;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Check every accepted byte against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_bytes++;
            if (want_q.size() == 0) begin
                $error("unexpected byte: out_byte=%02h last_byte=%0b", o_out_byte, o_last_byte);
                n_err++;
            end else begin
                head_byte = want_q.pop_front();
                if (o_out_byte !== head_byte.data) begin
                    $error("out_byte mismatch: expected %02h, actual %02h",
                           head_byte.data, o_out_byte);
                    n_err++;
                end
                if (o_last_byte !== head_byte.last) begin
                    $error("last_byte mismatch: expected %0b, actual %0b",
                           head_byte.last, o_last_byte);
                    n_err++;
                end
            end
            // Draw the stall ahead of the next byte
            stall_left = rx_idle_en ? $urandom_range(0, 6) : 0;
        end
    end

    // Watchdog: end the run if it hangs
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d bytes still owed", cycle_cnt, want_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Lead-byte range edges, a negative and a wide opcode
    task automatic test_opcode_ranges();
        send_item(bve_pkg::CMD_OPCODE, 64'd191);
        send_item(bve_pkg::CMD_OPCODE, 64'd192);
        send_item(bve_pkg::CMD_OPCODE, 64'd12288);
        send_item(bve_pkg::CMD_OPCODE, 64'd786432);
        send_item(bve_pkg::CMD_OPCODE, 64'd50331648);
        send_item(bve_pkg::CMD_OPCODE, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // Prefix edges, the five-byte form and a negative low word
    task automatic test_index_ranges();
        send_item(bve_pkg::CMD_INDEX, 64'd127);
        send_item(bve_pkg::CMD_INDEX, 64'h4000);
        send_item(bve_pkg::CMD_INDEX, 64'h1234_5678_1000_0000);
        send_item(bve_pkg::CMD_INDEX, 64'h0000_0000_8000_0005);
    endtask

    // Unsigned and signed varints, including the negative collapse
    task automatic test_varint_edges();
        send_item(bve_pkg::CMD_UVAR, 64'h7F);
        send_item(bve_pkg::CMD_UVAR, 64'h0100_0000_0000_0000);
        send_item(bve_pkg::CMD_UVAR, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(bve_pkg::CMD_UVAR, 64'h8000_0000_0000_0000);
        send_item(bve_pkg::CMD_SVAR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(bve_pkg::CMD_SVAR, 64'h8000_0000_0000_0000);
        send_item(bve_pkg::CMD_SVAR, 64'h7FFF_FFFF_FFFF_FFFF);
    endtask

    // Zero, one, negative zero, an all-ones NaN and the smallest subnormal
    task automatic test_double_patterns();
        send_item(bve_pkg::CMD_DOUBLE, 64'h0000_0000_0000_0000);
        send_item(bve_pkg::CMD_DOUBLE, 64'h3FF0_0000_0000_0000);
        send_item(bve_pkg::CMD_DOUBLE, 64'h8000_0000_0000_0000);
        send_item(bve_pkg::CMD_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(bve_pkg::CMD_DOUBLE, 64'h0000_0000_0000_0001);
    endtask

    // Codes with no encoding must produce nothing
    task automatic test_unused_codes();
        send_item(CMD_UNUSED_LO, 64'hDEAD_BEEF_0123_4567);
        send_item(CMD_UNUSED_HI, 64'h0);
    endtask

    // Random items in phases; each phase picks its own idling on both sides
    task automatic test_random_mix();
        int counted;
        logic [2:0] cmd;
        logic [63:0] value;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 50 == 0) begin
                tx_idle_en = ($urandom_range(0, 2) != 0);
                rx_idle_en = ($urandom_range(0, 2) != 0);
            end
            // Keep unused codes rare; they do not count toward the total
            if ($urandom_range(0, 19) == 0)
                cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            else
                cmd = 3'($urandom_range(bve_pkg::CMD_OPCODE, bve_pkg::CMD_DOUBLE));
            value = (cmd == bve_pkg::CMD_DOUBLE) ? rand_double() : rand_word();
            send_item(cmd, value);
            if (cmd <= bve_pkg::CMD_DOUBLE)
                counted++;
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Hold the output off for a long stretch while items keep coming, so the
    // block fills and stalls its input
    task automatic test_backpressure();
        tx_idle_en  = 1'b0;
        hold_cycles = 300;
        repeat (40)
            send_item(3'($urandom_range(bve_pkg::CMD_OPCODE, bve_pkg::CMD_DOUBLE)),
                      rand_word());
        tx_idle_en = 1'b1;
    endtask

    initial begin
        // Hold reset, then release it at a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_opcode_ranges();
        test_index_ranges();
        test_varint_edges();
        test_double_patterns();
        test_unused_codes();
        test_backpressure();
        test_random_mix();

        i_valid <= 1'b0;
        // Drain what is owed, then watch a while for stray bytes
        while (want_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d items over all five formats (%0d with unused codes), checked %0d bytes",
                 n_sent, n_silent, n_bytes);
        $display("with random idling on both sides and one long output hold-off.");
        if (n_err == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
sv/bve_pkg.sv
sv/bve_alu.sv
sv/bve_fmt.sv
sv/bytecode_varint_encoder_top.sv
tb/tb.sv
